/* src/icmpe_pkg.sv */
// Shared types and protocol constants for the ICMP echo responder.
package icmpe_pkg;

  // Frame header geometry.
  localparam int unsigned HDR_WORDS = 5;
  localparam int unsigned HDR_BYTES = 40;
  localparam int unsigned LANES     = 4;

  // Protocol field values.
  localparam logic [15:0] ETHERTYPE_IPV4    = 16'h0800;
  localparam logic [7:0]  IP_PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQUEST = 8'd8;
  localparam logic [7:0]  ICMP_ECHO_REPLY   = 8'd0;
  localparam logic [7:0]  ICMP_CODE_ECHO    = 8'd0;

  // Full word byte count and the byte count of a patch word.
  localparam logic [3:0] FULL_BYTES  = 4'd8;
  localparam logic [3:0] PATCH_BYTES = 4'd2;

  // The five header words, word 0 first.
  typedef logic [HDR_WORDS-1:0][63:0] hdr_words_t;

  // One 16-bit chunk per checksum lane, lane 0 holds the top of the word.
  typedef logic [LANES-1:0][15:0] lane_chunks_t;

  // Verdict of the header check.
  typedef struct packed {
    logic        pass;
    logic [15:0] ip_csum;
  } hdr_eval_t;

endpackage

/* src/icmpe_lane.sv */
// One checksum lane: keeps the valid bytes of a 16-bit chunk of the word.
module icmpe_lane (
  input  logic [1:0]  lane_idx_i,
  input  logic [15:0] chunk_i,
  input  logic [3:0]  byte_cnt_i,
  output logic [15:0] chunk_o
);

  logic [3:0] hi_pos;
  logic [3:0] lo_pos;
  logic       keep_hi;
  logic       keep_lo;

  // Byte positions of this chunk within the word, counted from the top.
  assign hi_pos  = {1'b0, lane_idx_i, 1'b0};
  assign lo_pos  = {1'b0, lane_idx_i, 1'b1};
  assign keep_hi = hi_pos < byte_cnt_i;
  assign keep_lo = lo_pos < byte_cnt_i;

  // Bytes beyond the count read as zero.
  assign chunk_o = {chunk_i[15:8] & {8{keep_hi}}, chunk_i[7:0] & {8{keep_lo}}};

endmodule

/* src/icmpe_merge.sv */
// Merge stage: adds the lane chunks into the running ICMP sum and folds it.
module icmpe_merge (
  input  logic [15:0]                 sum_i,
  input  icmpe_pkg::lane_chunks_t     chunks_i,
  output logic [15:0]                 sum_o,
  output logic [63:0]                 word_o
);

  logic [18:0] total;
  logic [16:0] fold1;
  logic [16:0] fold2;

  // Wide sum of the running value and all four lanes.
  assign total = 19'(sum_i) + 19'(chunks_i[0]) + 19'(chunks_i[1])
               + 19'(chunks_i[2]) + 19'(chunks_i[3]);

  // Two end-around carry folds bring the sum back to 16 bits.
  assign fold1 = 17'(total[15:0]) + 17'(total[18:16]);
  assign fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
  assign sum_o = fold2[15:0];

  // Masked word, rebuilt from the lanes.
  assign word_o = {chunks_i[0], chunks_i[1], chunks_i[2], chunks_i[3]};

endmodule

/* src/icmpe_hdr.sv */
// Header check and rewrite: filter, address swap and IP header checksum.
module icmpe_hdr (
  input  icmpe_pkg::hdr_words_t hold_i,
  input  logic [15:0]           ip_csum_i,
  output icmpe_pkg::hdr_eval_t  eval_o,
  output icmpe_pkg::hdr_words_t reply_o
);

  logic [63:0] w0;
  logic [63:0] w1;
  logic [63:0] w2;
  logic [63:0] w3;
  logic [63:0] w4;
  logic [19:0] ip_total;
  logic [16:0] ip_fold1;
  logic [16:0] ip_fold2;

  assign w0 = hold_i[0];
  assign w1 = hold_i[1];
  assign w2 = hold_i[2];
  assign w3 = hold_i[3];
  assign w4 = hold_i[4];

  // Filter on ethertype, IP protocol, ICMP type and ICMP code.
  assign eval_o.pass = (w1[31:16] == icmpe_pkg::ETHERTYPE_IPV4) &&
                       (w2[7:0] == icmpe_pkg::IP_PROTO_ICMP) &&
                       (w4[47:40] == icmpe_pkg::ICMP_ECHO_REQUEST) &&
                       (w4[39:32] == icmpe_pkg::ICMP_CODE_ECHO);

  // IP header sum over bytes 14 to 33 with the checksum field taken as zero.
  assign ip_total = 20'(w1[15:0]) + 20'(w2[63:48]) + 20'(w2[47:32])
                  + 20'(w2[31:16]) + 20'(w2[15:0]) + 20'(w3[47:32])
                  + 20'(w3[31:16]) + 20'(w3[15:0]) + 20'(w4[63:48]);
  assign ip_fold1 = 17'(ip_total[15:0]) + 17'(ip_total[19:16]);
  assign ip_fold2 = 17'(ip_fold1[15:0]) + 17'(ip_fold1[16]);
  assign eval_o.ip_csum = ~ip_fold2[15:0];

  // Reply words: MAC swap, IP swap, new checksum, echo reply type.
  assign reply_o[0] = {w0[15:0], w1[63:32], w0[63:48]};
  assign reply_o[1] = {w0[47:16], w1[31:0]};
  assign reply_o[2] = w2;
  assign reply_o[3] = {ip_csum_i, w3[15:0], w4[63:48], w3[47:32]};
  assign reply_o[4] = {w3[31:16], icmpe_pkg::ICMP_ECHO_REPLY, w4[39:32],
                       16'h0000, w4[15:0]};

endmodule

/* src/icmp_echo_responder.sv */
// A streamed word appears at the output in the cycle after it is taken. The
// fifth header word starts the header check; on a pass the five reply header
// words leave one per cycle unless the output stalls, and input is held
// meanwhile. Streaming takes one word per cycle unless the output stalls; each
// reply frame ends with a checksum patch word. Reset clears all control state;
// the header store is not reset and is always filled before it is read.
module icmp_echo_responder #(
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] in_word_i,
  input  logic [3:0]  in_bytes_i,
  input  logic        in_last_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [63:0] out_word_o,
  output logic [3:0]  out_bytes_o,
  output logic        out_frame_end_o,
  output logic        out_patch_o,
  output logic        out_run_end_o
);

  localparam int unsigned FB_W = $clog2(MAX_FRAME_BYTES + 9);
  localparam logic [FB_W-1:0] FB_MAX  = FB_W'(MAX_FRAME_BYTES);
  localparam logic [FB_W-1:0] FB_HDR  = FB_W'(icmpe_pkg::HDR_BYTES);
  localparam logic [FB_W-1:0] FB_STEP = FB_W'(8);
  localparam logic [2:0]      LAST_HDR = 3'(icmpe_pkg::HDR_WORDS - 1);
  localparam logic [2:0]      NUM_HDR  = 3'(icmpe_pkg::HDR_WORDS);

  // Sequencer states.
  localparam logic [1:0] ST_RUN   = 2'd0;
  localparam logic [1:0] ST_EVAL  = 2'd1;
  localparam logic [1:0] ST_HDR   = 2'd2;
  localparam logic [1:0] ST_PATCH = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [2:0]              word_idx_q, word_idx_d;
  logic                    dropping_q, dropping_d;
  logic [15:0]             icmp_sum_q, icmp_sum_d;
  logic [FB_W-1:0]         fb_q, fb_d;
  logic                    last_hdr_q, last_hdr_d;
  logic [3:0]              cnt_hdr_q, cnt_hdr_d;
  logic [2:0]              hdr_k_q, hdr_k_d;
  logic [15:0]             ip_csum_q, ip_csum_d;
  icmpe_pkg::hdr_words_t   hold_q;

  logic                    out_valid_q, out_valid_d;
  logic [63:0]             out_word_q, out_word_d;
  logic [3:0]              out_bytes_q, out_bytes_d;
  logic                    out_frame_end_q, out_frame_end_d;
  logic                    out_patch_q, out_patch_d;
  logic                    out_run_end_q, out_run_end_d;

  logic                    load;
  logic                    accept;
  logic                    in_hdr;
  logic [3:0]              cnt_sat;
  logic [3:0]              cnt;
  logic                    over;
  logic [FB_W-1:0]         rem;
  logic [FB_W-1:0]         fb_next;
  logic [3:0]              allowed;
  logic [3:0]              lane_cnt;
  icmpe_pkg::lane_chunks_t raw_chunks;
  icmpe_pkg::lane_chunks_t kept_chunks;
  logic [15:0]             merged_sum;
  logic [63:0]             masked_word;
  icmpe_pkg::hdr_eval_t    hdr_eval;
  icmpe_pkg::hdr_words_t   reply_words;

  // Handshake: the output register takes a word when empty or drained.
  assign load       = !out_valid_q || !out_stall_i;
  assign in_stall_o = (state_q != ST_RUN) || !load;
  assign accept     = in_valid_i && !in_stall_o;

  // Byte count of the word: full unless last, capped at eight.
  assign cnt_sat = (in_bytes_i > icmpe_pkg::FULL_BYTES) ? icmpe_pkg::FULL_BYTES : in_bytes_i;
  assign cnt     = in_last_i ? cnt_sat : icmpe_pkg::FULL_BYTES;
  assign in_hdr  = word_idx_q < NUM_HDR;

  // Frame length cap: bytes past the limit are discarded.
  assign over    = fb_q >= FB_MAX;
  assign rem     = FB_MAX - fb_q;
  assign fb_next = ((fb_q + FB_STEP) > FB_MAX) ? FB_MAX : fb_q + FB_STEP;
  always_comb begin
    if (over) begin
      allowed = 4'd0;
    end else if (rem < FB_W'(cnt)) begin
      allowed = rem[3:0];
    end else begin
      allowed = cnt;
    end
  end
  assign lane_cnt = in_hdr ? cnt : allowed;

  // Checksum lanes, one per 16-bit chunk of the word.
  for (genvar g = 0; g < icmpe_pkg::LANES; g++) begin : g_lane
    assign raw_chunks[g] = in_word_i[63-16*g -: 16];
    icmpe_lane u_lane (
      .lane_idx_i (2'(g)),
      .chunk_i    (raw_chunks[g]),
      .byte_cnt_i (lane_cnt),
      .chunk_o    (kept_chunks[g])
    );
  end

  // Merge of the lanes into the running ICMP sum.
  icmpe_merge u_merge (
    .sum_i    (icmp_sum_q),
    .chunks_i (kept_chunks),
    .sum_o    (merged_sum),
    .word_o   (masked_word)
  );

  // Header check and reply header words.
  icmpe_hdr u_hdr (
    .hold_i    (hold_q),
    .ip_csum_i (ip_csum_q),
    .eval_o    (hdr_eval),
    .reply_o   (reply_words)
  );

  // Sequencer and output word selection.
  always_comb begin
    state_d         = state_q;
    word_idx_d      = word_idx_q;
    dropping_d      = dropping_q;
    icmp_sum_d      = icmp_sum_q;
    fb_d            = fb_q;
    last_hdr_d      = last_hdr_q;
    cnt_hdr_d       = cnt_hdr_q;
    hdr_k_d         = hdr_k_q;
    ip_csum_d       = ip_csum_q;
    out_valid_d     = out_valid_q;
    out_word_d      = out_word_q;
    out_bytes_d     = out_bytes_q;
    out_frame_end_d = out_frame_end_q;
    out_patch_d     = out_patch_q;
    out_run_end_d   = out_run_end_q;
    if (load) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_RUN: begin
        if (accept) begin
          if (dropping_q) begin
            if (in_last_i) begin
              word_idx_d = 3'd0;
              dropping_d = 1'b0;
              icmp_sum_d = 16'd0;
              fb_d       = '0;
            end
          end else if (in_hdr) begin
            word_idx_d = word_idx_q + 3'd1;
            if (word_idx_q == LAST_HDR) begin
              last_hdr_d = in_last_i;
              cnt_hdr_d  = cnt;
              fb_d       = FB_HDR;
              state_d    = ST_EVAL;
            end else if (in_last_i) begin
              word_idx_d = 3'd0;
            end
          end else begin
            if (!over) begin
              fb_d = fb_next;
            end
            if ((allowed != 4'd0) || in_last_i) begin
              icmp_sum_d      = merged_sum;
              out_valid_d     = 1'b1;
              out_word_d      = masked_word;
              out_bytes_d     = allowed;
              out_frame_end_d = in_last_i;
              out_patch_d     = 1'b0;
              out_run_end_d   = !in_last_i;
              if (in_last_i) begin
                state_d = ST_PATCH;
              end
            end
          end
        end
      end
      ST_EVAL: begin
        if (hdr_eval.pass) begin
          ip_csum_d  = hdr_eval.ip_csum;
          icmp_sum_d = hold_q[LAST_HDR][15:0];
          hdr_k_d    = 3'd0;
          state_d    = ST_HDR;
        end else begin
          state_d = ST_RUN;
          if (last_hdr_q) begin
            word_idx_d = 3'd0;
            icmp_sum_d = 16'd0;
            fb_d       = '0;
          end else begin
            dropping_d = 1'b1;
          end
        end
      end
      ST_HDR: begin
        if (load) begin
          out_valid_d     = 1'b1;
          out_word_d      = reply_words[hdr_k_q];
          out_patch_d     = 1'b0;
          if (hdr_k_q == LAST_HDR) begin
            out_bytes_d     = cnt_hdr_q;
            out_frame_end_d = last_hdr_q;
            out_run_end_d   = !last_hdr_q;
            state_d         = last_hdr_q ? ST_PATCH : ST_RUN;
          end else begin
            out_bytes_d     = icmpe_pkg::FULL_BYTES;
            out_frame_end_d = 1'b0;
            out_run_end_d   = 1'b0;
            hdr_k_d         = hdr_k_q + 3'd1;
          end
        end
      end
      ST_PATCH: begin
        if (load) begin
          out_valid_d     = 1'b1;
          out_word_d      = {48'd0, ~icmp_sum_q};
          out_bytes_d     = icmpe_pkg::PATCH_BYTES;
          out_frame_end_d = 1'b0;
          out_patch_d     = 1'b1;
          out_run_end_d   = 1'b1;
          word_idx_d      = 3'd0;
          dropping_d      = 1'b0;
          icmp_sum_d      = 16'd0;
          fb_d            = '0;
          state_d         = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      word_idx_q  <= 3'd0;
      dropping_q  <= 1'b0;
      icmp_sum_q  <= 16'd0;
      fb_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      word_idx_q  <= word_idx_d;
      dropping_q  <= dropping_d;
      icmp_sum_q  <= icmp_sum_d;
      fb_q        <= fb_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    last_hdr_q      <= last_hdr_d;
    cnt_hdr_q       <= cnt_hdr_d;
    hdr_k_q         <= hdr_k_d;
    ip_csum_q       <= ip_csum_d;
    out_word_q      <= out_word_d;
    out_bytes_q     <= out_bytes_d;
    out_frame_end_q <= out_frame_end_d;
    out_patch_q     <= out_patch_d;
    out_run_end_q   <= out_run_end_d;
  end

  // Header store, filled one word at a time.
  always_ff @(posedge clk_i) begin
    if (accept && !dropping_q && in_hdr) begin
      hold_q[word_idx_q] <= masked_word;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_word_o      = out_word_q;
  assign out_bytes_o     = out_bytes_q;
  assign out_frame_end_o = out_frame_end_q;
  assign out_patch_o     = out_patch_q;
  assign out_run_end_o   = out_run_end_q;

endmodule

/* src/icmpe_chk.sv */
// Port-level checks for the ICMP echo responder, bound to the top level.
module icmpe_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [63:0] out_word_o,
  input logic [3:0]  out_bytes_o,
  input logic        out_frame_end_o,
  input logic        out_patch_o,
  input logic        out_run_end_o
);

  // A patch word carries only a 16-bit checksum and closes the run.
  a_patch_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_patch_o) |->
      (out_bytes_o == 4'd2) && !out_frame_end_o && out_run_end_o &&
      (out_word_o[63:16] == 48'd0))
    else $error("patch word malformed");

  // The word that ends a reply frame is followed directly by its patch word.
  a_patch_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && out_frame_end_o) |=> (out_valid_o && out_patch_o))
    else $error("frame end not followed by patch");

  // No output word claims more than eight bytes.
  a_bytes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_bytes_o <= 4'd8))
    else $error("output byte count out of range");

  // A stalled output word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(out_word_o) && $stable(out_bytes_o) &&
       $stable(out_patch_o)))
    else $error("stalled output word changed");

  // A waiting output word holds off the input.
  a_in_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> in_stall_o)
    else $error("input taken while output word waits");

endmodule

bind icmp_echo_responder icmpe_chk u_icmpe_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .out_word_o      (out_word_o),
  .out_bytes_o     (out_bytes_o),
  .out_frame_end_o (out_frame_end_o),
  .out_patch_o     (out_patch_o),
  .out_run_end_o   (out_run_end_o)
);
